@@ rtl/gcmb_pkg.sv @@
package gcmb_pkg;

  // Size limits of the block
  localparam int MAX_RADIUS = 6;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int KDEPTH   = SIDE_MAX * SIDE_MAX;
  localparam int LDEPTH   = SIDE_MAX * MAX_WIDTH;

  // Field and index widths
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DIMW  = 11;
  localparam int RADW  = 3;
  localparam int SIDEW = $clog2(SIDE_MAX + 1);
  localparam int SLOTW = $clog2(SIDE_MAX);
  localparam int KAW   = $clog2(KDEPTH);
  localparam int LAW   = $clog2(LDEPTH);
  localparam int CRDW  = DIMW + 3;
  localparam int PIXW  = 8;
  localparam int COEFW = 16;
  localparam int IDXW  = 8;
  localparam int VALW  = 16;
  localparam int PRODW = PIXW + COEFW;
  localparam int ROWW  = PRODW + $clog2(SIDE_MAX);
  localparam int ACCW  = PRODW + $clog2(KDEPTH);
  localparam int IN_DW  = 32;
  localparam int OUT_DW = 40;

  // Kernel row sequencer: setup cycles and step counter width
  localparam int SEQ_PRE = 3;
  localparam int SEQW    = $clog2(SEQ_PRE + 2 * SIDE_MAX + 2);

  // Rounding offset for Q8.16 -> Q8.8
  localparam int ROUND_HALF = 128;

  // Reciprocal of the line count for row -> line slot
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / SIDE_MAX;

  // Input item kinds
  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic [DIMW-1:0] w;
    logic [DIMW-1:0] h;
    logic [RADW-1:0] rad;
  } geo_t;

  typedef struct packed {
    logic          start;
    logic [XW-1:0] ox;
    logic [YW-1:0] oy;
  } job_t;

  typedef struct packed {
    logic            done;
    logic [VALW-1:0] value;
  } res_t;

  // Symmetric border: -1-k reads k, n+k reads n-1-k, then clamp into the frame
  function automatic logic [DIMW-1:0] mirror(input logic signed [CRDW-1:0] c,
                                             input logic [DIMW-1:0] n);
    logic signed [CRDW-1:0] t;
    logic signed [CRDW-1:0] nn;
    logic signed [CRDW-1:0] one;
    nn  = $signed(CRDW'(n));
    one = $signed(CRDW'(1));
    if (c < 0) begin
      t = -c - one;
    end else if (c >= nn) begin
      t = (nn <<< 1) - one - c;
    end else begin
      t = c;
    end
    if (t < 0) t = '0;
    if (t > nn - one) t = nn - one;
    return t[DIMW-1:0];
  endfunction

endpackage

@@ rtl/gcmb_ram.sv @@
module gcmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gcmb_cell.sv @@
module gcmb_cell import gcmb_pkg::*; (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [COEFW-1:0] coef_in,
  output logic [COEFW-1:0] coef_out,
  input  logic             mac_en,
  input  logic [PIXW-1:0]  pix,
  input  logic [ROWW-1:0]  sum_in,
  output logic [ROWW-1:0]  sum_out
);

  logic [COEFW-1:0] coef_r;
  logic [ROWW-1:0]  sum_r;
  logic [PRODW-1:0] prod;

  assign prod = PRODW'(pix) * PRODW'(coef_r);

  // Coefficient shifts along the row; partial sum moves one cell per step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      coef_r <= coef_in;
    end
    if (mac_en) begin
      sum_r <= sum_in + ROWW'(prod);
    end
  end

  assign coef_out = coef_r;
  assign sum_out  = sum_r;

endmodule

@@ rtl/gcmb_filter.sv @@
module gcmb_filter import gcmb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  geo_t             geo,
  input  job_t             job,
  output res_t             res,
  output logic [KAW-1:0]   k_raddr,
  input  logic [COEFW-1:0] k_rdata,
  output logic [LAW-1:0]   l_raddr,
  input  logic [PIXW-1:0]  l_rdata
);

  logic                   busy_r;
  logic [SEQW-1:0]        m_r;
  logic [SIDEW-1:0]       j_r;
  logic [XW-1:0]          ox_r;
  logic signed [CRDW-1:0] rr_r;
  logic signed [CRDW-1:0] cc_r;
  logic [KAW-1:0]         kidx_r;
  logic [KAW-1:0]         kbase_r;
  logic [YW-1:0]          rm_r;
  logic [YW-1:0]          re_r;
  logic                   rout_r;
  logic [YW-1:0]          qm_r;
  logic [YW-1:0]          qe_r;
  logic [SLOTW-1:0]       slotm_r;
  logic [SLOTW-1:0]       slote_r;
  logic                   kv_r;
  logic                   pv_r;
  logic [ACCW-1:0]        acc_r;
  logic                   done_r;
  logic [VALW-1:0]        value_r;

  logic [SIDEW-1:0]       side;
  logic [SEQW-1:0]        pst;
  logic [SEQW-1:0]        pend;
  logic [SEQW-1:0]        aend;
  logic                   k_issue;
  logic                   p_issue;
  logic signed [CRDW-1:0] ws;
  logic signed [CRDW-1:0] hs;
  logic signed [CRDW-1:0] rads;
  logic [DIMW-1:0]        rmir;
  logic [DIMW-1:0]        cmir;
  logic [YW+RECIP_SH-1:0] pm;
  logic [YW+RECIP_SH-1:0] pe;
  logic                   cout;
  logic [XW-1:0]          cm;
  logic [SLOTW-1:0]       slot;
  logic [COEFW-1:0]       coefs [SIDE_MAX];
  logic [ROWW-1:0]        sums  [SIDE_MAX];
  logic [ROWW-1:0]        chain_out;
  logic [ACCW-1:0]        total;
  logic [VALW-1:0]        sat;

  // Line slot of a frame row: r - 13*floor(r/13), quotient off by at most one
  function automatic logic [SLOTW-1:0] slot_of(input logic [YW-1:0] r,
                                               input logic [YW-1:0] q);
    logic [YW-1:0] rem;
    rem = r - YW'(q * SIDE_MAX);
    if (rem >= YW'(SIDE_MAX)) rem = rem - YW'(SIDE_MAX);
    return rem[SLOTW-1:0];
  endfunction

  assign side = {geo.rad, 1'b0} + SIDEW'(1);
  assign pst  = SEQW'(SEQ_PRE) + SEQW'(side);
  assign pend = pst + SEQW'(side);
  assign aend = pend + SEQW'(1);
  assign k_issue = busy_r && (m_r >= SEQW'(SEQ_PRE)) && (m_r < pst);
  assign p_issue = busy_r && (m_r >= pst) && (m_r < pend);

  assign ws   = $signed(CRDW'(geo.w));
  assign hs   = $signed(CRDW'(geo.h));
  assign rads = $signed(CRDW'(geo.rad));

  // Row setup terms
  assign rmir = mirror(rr_r, geo.h);
  assign pm   = (YW+RECIP_SH)'(rm_r) * (YW+RECIP_SH)'(RECIP);
  assign pe   = (YW+RECIP_SH)'(re_r) * (YW+RECIP_SH)'(RECIP);

  // Pixel address: mirrored, or nearest corner when both coordinates are outside
  assign cmir = mirror(cc_r, geo.w);
  assign cout = (cc_r < 0) || (cc_r >= ws);
  always_comb begin
    if (cout && rout_r) begin
      cm   = (cc_r < 0) ? '0 : XW'(geo.w - DIMW'(1));
      slot = slote_r;
    end else begin
      cm   = cmir[XW-1:0];
      slot = slotm_r;
    end
  end

  assign l_raddr = LAW'(slot * MAX_WIDTH) + LAW'(cm);
  assign k_raddr = kidx_r;

  // Row of MAC cells, transposed form
  for (genvar k = 0; k < SIDE_MAX; k++) begin : g_cell
    gcmb_cell u_cell (
      .clk      (clk),
      .shift_en (kv_r),
      .coef_in  ((k == 0) ? k_rdata : coefs[(k == 0) ? 0 : k-1]),
      .coef_out (coefs[k]),
      .mac_en   (pv_r),
      .pix      (l_rdata),
      .sum_in   ((k == 0) ? '0 : sums[(k == 0) ? 0 : k-1]),
      .sum_out  (sums[k])
    );
  end

  assign chain_out = sums[SLOTW'(side - SIDEW'(1))];
  assign total     = acc_r + ACCW'(chain_out);
  assign sat       = (|total[ACCW-1:VALW+8]) ? '1 : total[VALW+7:8];

  // Sequencer: per kernel row, setup, coefficient load, pixel pass, row sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      kv_r   <= 1'b0;
      pv_r   <= 1'b0;
      m_r    <= '0;
      j_r    <= '0;
    end else begin
      done_r <= !job.start && busy_r && (m_r == aend) && (j_r == side - SIDEW'(1));
      kv_r   <= k_issue;
      pv_r   <= p_issue;
      if (job.start) begin
        busy_r  <= 1'b1;
        m_r     <= '0;
        j_r     <= '0;
        ox_r    <= job.ox;
        rr_r    <= $signed(CRDW'(job.oy)) - rads;
        kbase_r <= '0;
        acc_r   <= ACCW'(ROUND_HALF);
      end else if (busy_r) begin
        if (m_r == '0) begin
          rout_r <= (rr_r < 0) || (rr_r >= hs);
          rm_r   <= rmir[YW-1:0];
          re_r   <= (rr_r < 0) ? '0 : YW'(geo.h - DIMW'(1));
          cc_r   <= $signed(CRDW'(ox_r)) - rads;
          kidx_r <= kbase_r + KAW'(side) - KAW'(1);
        end
        if (m_r == SEQW'(1)) begin
          qm_r <= pm[YW+RECIP_SH-1:RECIP_SH];
          qe_r <= pe[YW+RECIP_SH-1:RECIP_SH];
        end
        if (m_r == SEQW'(2)) begin
          slotm_r <= slot_of(rm_r, qm_r);
          slote_r <= slot_of(re_r, qe_r);
        end
        if (k_issue) kidx_r <= kidx_r - KAW'(1);
        if (p_issue) cc_r <= cc_r + $signed(CRDW'(1));
        if (m_r == aend) begin
          acc_r <= total;
          if (j_r == side - SIDEW'(1)) begin
            busy_r  <= 1'b0;
            value_r <= sat;
          end else begin
            j_r     <= j_r + SIDEW'(1);
            rr_r    <= rr_r + $signed(CRDW'(1));
            kbase_r <= kbase_r + KAW'(side);
            m_r     <= '0;
          end
        end else begin
          m_r <= m_r + SEQW'(1);
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = value_r;

endmodule

@@ rtl/gaussian_conv2d_mirror_border.sv @@
// Gaussian pre-smoothing filter with a symmetric mirrored border.
// Input stream: in_tuser selects the kind of request (coefficient load,
// pixel in raster order, flush position after the frame). Coefficient loads
// and pixels that give no result leave the block ready for the next request.
// Output stream: one request per filtered pixel, tlast on the final result
// of an input request, tuser on the frame's final pixel. Pixels near the
// right edge come out at row ends; the last radius rows come out on flushes.
// Each result is built by a row of 13 MAC cells, one kernel row at a time:
// with side = 2*radius+1 a result takes side kernel rows, and an input request
// causes up to radius+1 results, produced one after another.
// The kernel RAM and line RAM each give one word per cycle, which paces the
// cell row. Configuration writes (cfg_we) are taken in any cycle and restart
// the frame position; issue them only while the block is idle.
// Reset (rst_n low, synchronous) restores the default frame geometry and the
// position; kernel and line RAM contents stay undefined until written.
// While the receiver stalls, a finished result stays in the output register;
// a new input request can still be taken once the current one is finished.
module gaussian_conv2d_mirror_border import gcmb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // coef_index, coef_value, pixel
  input  logic [1:0]        in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // out_x, out_y, value, zero pad
  output logic              out_tlast,  // last
  output logic              out_tuser,  // frame_end
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DIMW-1:0]   cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_PUT} state_t;

  state_t           state_r;
  logic [DIMW-1:0]  width_r;
  logic [DIMW-1:0]  height_r;
  logic [RADW-1:0]  rad_r;
  logic [XW-1:0]    col_r;
  logic [DIMW-1:0]  row_r;
  logic [SLOTW-1:0] wslot_r;
  logic [XW-1:0]    ox_r;
  logic [XW-1:0]    hi_r;
  logic [YW-1:0]    oy_r;
  logic             start_r;
  logic             out_valid_r;
  logic [XW-1:0]    out_x_r;
  logic [YW-1:0]    out_y_r;
  logic [VALW-1:0]  out_val_r;
  logic             out_last_r;
  logic             out_fe_r;

  logic [DIMW-1:0]  w_eff;
  logic [DIMW-1:0]  h_eff;
  logic [RADW-1:0]  rad_eff;
  geo_t             geo;
  job_t             job;
  res_t             res;
  logic             accept;
  logic [IDXW-1:0]  coef_index;
  logic [COEFW-1:0] coef_value;
  logic [PIXW-1:0]  pixel;
  logic [DIMW:0]    hr;
  logic             row_wrap;
  logic [XW-1:0]    x0;
  logic [DIMW-1:0]  y0;
  logic [SLOTW-1:0] ws0;
  logic             take;
  logic             at_end;
  logic             emit;
  logic [XW-1:0]    lo;
  logic [XW-1:0]    hi;
  logic [DIMW-1:0]  x1;
  logic [DIMW:0]    y1;
  logic             put;
  logic             cfg_clr;
  logic             k_we;
  logic             l_we;
  logic [LAW-1:0]   l_waddr;
  logic [KAW-1:0]   k_raddr;
  logic [COEFW-1:0] k_rdata;
  logic [LAW-1:0]   l_raddr;
  logic [PIXW-1:0]  l_rdata;

  // Effective geometry, clamped into range
  assign w_eff = (width_r == '0) ? DIMW'(1) :
                 (width_r > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? DIMW'(1) :
                 (height_r > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT) : height_r;
  assign rad_eff = (rad_r > RADW'(MAX_RADIUS)) ? RADW'(MAX_RADIUS) : rad_r;
  assign geo = '{w: w_eff, h: h_eff, rad: rad_eff};

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign coef_index = in_tdata[IDXW-1:0];
  assign coef_value = in_tdata[IDXW+COEFW-1:IDXW];
  assign pixel      = in_tdata[IDXW+COEFW+PIXW-1:IDXW+COEFW];

  // Current raster position and which outputs it completes
  assign hr       = (DIMW+1)'(h_eff) + (DIMW+1)'(rad_eff);
  assign row_wrap = ((DIMW+1)'(row_r) >= hr);
  assign x0       = (DIMW'(col_r) >= w_eff) ? '0 : col_r;
  assign y0       = row_wrap ? '0 : row_r;
  assign ws0      = row_wrap ? '0 : wslot_r;
  assign take     = ((in_tuser == OP_PIXEL) && (y0 < h_eff)) ||
                    ((in_tuser == OP_FLUSH) && (y0 >= h_eff));
  assign at_end   = (DIMW'(x0) == w_eff - DIMW'(1));
  assign emit     = take && (y0 >= DIMW'(rad_eff)) &&
                    (at_end || (DIMW'(x0) >= DIMW'(rad_eff)));
  assign lo = (at_end && (DIMW'(x0) < DIMW'(rad_eff))) ? '0 : x0 - XW'(rad_eff);
  assign hi = at_end ? x0 : x0 - XW'(rad_eff);
  assign x1 = DIMW'(x0) + DIMW'(1);
  assign y1 = (DIMW+1)'(y0) + (DIMW+1)'(1);

  // Output register load, and register writes that restart the frame
  assign put     = (state_r == S_PUT) && (!out_valid_r || out_tready);
  assign cfg_clr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                              cfg_index == REG_RADIUS);

  // Store writes
  assign k_we    = accept && (in_tuser == OP_COEF) && (int'(coef_index) < KDEPTH);
  assign l_we    = accept && (in_tuser == OP_PIXEL) && (y0 < h_eff);
  assign l_waddr = LAW'(ws0 * MAX_WIDTH) + LAW'(x0);

  gcmb_ram #(.WIDTH(COEFW), .DEPTH(KDEPTH)) u_kernel_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (KAW'(coef_index)),
    .wdata (coef_value),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  gcmb_ram #(.WIDTH(PIXW), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (pixel),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign job = '{start: start_r, ox: ox_r, oy: oy_r};

  gcmb_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .geo     (geo),
    .job     (job),
    .res     (res),
    .k_raddr (k_raddr),
    .k_rdata (k_rdata),
    .l_raddr (l_raddr),
    .l_rdata (l_rdata)
  );

  // Control, position and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= DIMW'(640);
      height_r    <= DIMW'(480);
      rad_r       <= RADW'(3);
      col_r       <= '0;
      row_r       <= '0;
      wslot_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= ((state_r == S_IDLE) && accept && take && emit) ||
                     (put && (ox_r != hi_r));
      out_valid_r <= put || (out_valid_r && !out_tready);

      // Raster position; a register write starts a new frame
      if (cfg_clr) begin
        col_r   <= '0;
        row_r   <= '0;
        wslot_r <= '0;
      end else if ((state_r == S_IDLE) && accept && take) begin
        if (x1 >= w_eff) begin
          col_r <= '0;
          if (y1 >= hr) begin
            row_r   <= '0;
            wslot_r <= '0;
          end else begin
            row_r   <= y1[DIMW-1:0];
            wslot_r <= (ws0 == SLOTW'(SIDE_MAX - 1)) ? '0 : ws0 + SLOTW'(1);
          end
        end else begin
          col_r   <= x1[XW-1:0];
          row_r   <= y0;
          wslot_r <= ws0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && take && emit) begin
            ox_r    <= lo;
            hi_r    <= hi;
            oy_r    <= YW'(y0 - DIMW'(rad_eff));
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (res.done) state_r <= S_PUT;
        end
        S_PUT: begin
          if (put) begin
            out_x_r     <= ox_r;
            out_y_r     <= oy_r;
            out_val_r   <= res.value;
            out_last_r  <= (ox_r == hi_r);
            out_fe_r    <= (ox_r == XW'(w_eff - DIMW'(1))) &&
                           (oy_r == YW'(h_eff - DIMW'(1)));
            if (ox_r == hi_r) begin
              state_r <= S_IDLE;
            end else begin
              ox_r    <= ox_r + XW'(1);
              state_r <= S_RUN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Register write
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          REG_RADIUS: rad_r    <= cfg_data[RADW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW-XW-YW-VALW)'(0), out_val_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_fe_r;

endmodule

@@ rtl/gcmb_checker.sv @@
module gcmb_checker import gcmb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [1:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast,
  input logic              out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A coefficient load never blocks the next request
  a_coef_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_COEF |=> in_tready)
    else $error("coefficient load stalled input");

  // Frame's final pixel is always the final result of its request
  a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without last");

endmodule

bind gaussian_conv2d_mirror_border gcmb_checker u_gcmb_checker (.*);
